// ===== src/rpk_pkg.sv =====
// ----------------------------------------------------------------------------
// rpk_pkg
// shared types, codes and flag helpers for the remote power key controller
// ----------------------------------------------------------------------------
`default_nettype none

package rpk_pkg;

  localparam int unsigned LongPressW     = 16;
  localparam int unsigned TimeW          = 32;
  localparam logic [LongPressW-1:0] LongPressReset = 16'd1000;

  // switch position codes
  localparam logic [1:0] PosCenter = 2'd0;
  localparam logic [1:0] PosHigh   = 2'd1;
  localparam logic [1:0] PosLow    = 2'd2;

  typedef enum logic [2:0] {
    ST_OFF      = 3'd0,
    ST_ON       = 3'd1,
    ST_ON_REQ   = 3'd2,
    ST_DOWN_REQ = 3'd3,
    ST_REJECTED = 3'd4,
    ST_PROTECT  = 3'd5
  } pwr_state_t;

  typedef enum logic [1:0] {
    DG_OK     = 2'd0,
    DG_REJECT = 2'd1,
    DG_CLASSA = 2'd2,
    DG_STOP   = 2'd3
  } diag_t;

  typedef struct packed {
    logic [1:0]       power_position;
    logic [TimeW-1:0] now_ms;
    logic [7:0]       power_on_flags;
    logic [3:0]       power_down_flags;
  } rpk_in_t;

  typedef struct packed {
    logic [2:0] power_state;
    logic [7:0] block_mask;
    logic       hv_enable_request;
    logic       hv_disable_request;
    logic       orderly_shutdown;
    logic       req_refused;
    logic [1:0] diagnostic_code;
  } rpk_out_t;

  typedef struct packed {
    pwr_state_t       cur_state;
    logic [1:0]       held_position;
    logic [TimeW-1:0] hold_start_ms;
    logic             enable_latch;
    diag_t            last_diag;
  } rpk_state_t;

  // checks 0-4 and 7 fail when clear, estop and class-a fail when set
  function automatic logic [7:0] fail_mask(input logic [7:0] f);
    fail_mask = ((~f) & 8'h9F) | (f & 8'h60);
  endfunction

  function automatic logic down_ok(input logic [7:0] on_f, input logic [3:0] dn_f);
    down_ok = on_f[0] & on_f[1] & dn_f[0] & dn_f[1] & ~dn_f[2] & ~dn_f[3] & ~on_f[5];
  endfunction

endpackage

`default_nettype wire

// ===== src/rpk_core.sv =====
// ----------------------------------------------------------------------------
// rpk_core
// one update of the power key state machine: next state and result word
// ----------------------------------------------------------------------------
`default_nettype none

module rpk_core (
  input  rpk_pkg::rpk_in_t                      item,
  input  rpk_pkg::rpk_state_t                   st,
  input  logic [rpk_pkg::LongPressW-1:0]        long_press_ms,
  output rpk_pkg::rpk_state_t                   st_next,
  output rpk_pkg::rpk_out_t                     result
);
  import rpk_pkg::*;

  logic [7:0]       mask;
  logic             protect_hit;
  logic             pos_active;
  logic             pos_new;
  logic [TimeW-1:0] elapsed;
  logic             hold_short;
  logic             high_ok;
  logic             dn_ok;

  assign mask        = fail_mask(item.power_on_flags);
  assign protect_hit = item.power_on_flags[5] | item.power_on_flags[6];
  assign pos_active  = (item.power_position == PosHigh) || (item.power_position == PosLow);
  assign pos_new     = item.power_position != st.held_position;
  assign elapsed     = item.now_ms - st.hold_start_ms;
  assign hold_short  = elapsed < {{(TimeW-LongPressW){1'b0}}, long_press_ms};
  assign high_ok     = st.enable_latch | (mask == 8'h00);
  assign dn_ok       = down_ok(item.power_on_flags, item.power_down_flags);

  // next state
  always_comb begin
    st_next = st;
    if (protect_hit) begin
      st_next.cur_state = ST_PROTECT;
      st_next.last_diag = item.power_on_flags[6] ? DG_CLASSA : DG_STOP;
    end else if (!pos_active) begin
      st_next.held_position = item.power_position;
      st_next.hold_start_ms = item.now_ms;
      st_next.cur_state     = st.enable_latch ? ST_ON : ST_OFF;
      st_next.last_diag     = DG_OK;
    end else if (pos_new) begin
      st_next.held_position = item.power_position;
      st_next.hold_start_ms = item.now_ms;
    end else if (hold_short) begin
      st_next.cur_state = (item.power_position == PosHigh) ? ST_ON_REQ : ST_DOWN_REQ;
    end else if (item.power_position == PosHigh) begin
      if (high_ok) begin
        st_next.cur_state    = ST_ON;
        st_next.enable_latch = 1'b1;
        st_next.last_diag    = DG_OK;
      end else begin
        st_next.cur_state    = ST_REJECTED;
        st_next.enable_latch = 1'b0;
        st_next.last_diag    = DG_REJECT;
      end
    end else if (dn_ok) begin
      st_next.cur_state    = ST_OFF;
      st_next.enable_latch = 1'b0;
      st_next.last_diag    = DG_OK;
    end else begin
      st_next.cur_state = ST_REJECTED;
      st_next.last_diag = DG_REJECT;
    end
  end

  // result word
  always_comb begin
    logic acting;
    logic down_act;
    acting   = !protect_hit && pos_active && !pos_new && !hold_short;
    down_act = acting && (item.power_position == PosLow) && dn_ok;
    result.power_state        = st_next.cur_state;
    result.block_mask         = mask;
    result.hv_enable_request  = st_next.enable_latch;
    result.hv_disable_request = down_act;
    result.orderly_shutdown   = down_act;
    result.req_refused        = acting && ((item.power_position == PosHigh) ? !high_ok : !dn_ok);
    result.diagnostic_code    = st_next.last_diag;
  end

endmodule

`default_nettype wire

// ===== src/remote_power_key_fsm.sv =====
// ----------------------------------------------------------------------------
// remote_power_key_fsm
// remote power switch long-press controller with high-voltage enable latch
// ----------------------------------------------------------------------------
// usage
//   in channel  : in_valid / in_ready / in_data, one switch update per word
//   out channel : out_valid / out_ready / out_data, exactly one result word
//                 per accepted update, in order
//   cfg channel : cfg_valid / cfg_ready / cfg_data writes long_press_ms;
//                 always ready, write it only while the block is idle
// timing
//   an update is captured in the input register, evaluated against the held
//   state by combinational logic and lands in the result register once that
//   register has room; out_valid rises when it does
//   throughput is one word per cycle while out_ready stays high; the only loop
//   is the state register feeding the combinational update logic
// reset
//   rst (synchronous) empties both registers, returns to off with centre held,
//   clears the enable latch and diagnostic, and loads long_press_ms = 1000
// stall
//   when out_ready is low the result waits in the output register, the
//   input register still takes one more word, then in_ready drops
// ----------------------------------------------------------------------------
`default_nettype none

module remote_power_key_fsm (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rpk_pkg::LongPressW-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  rpk_pkg::rpk_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output rpk_pkg::rpk_out_t              out_data
);
  import rpk_pkg::*;

  // configuration
  logic [LongPressW-1:0] long_press_ms;

  // input register
  rpk_in_t in_reg;
  logic    in_full;

  // machine state
  rpk_state_t st;
  rpk_state_t st_next;

  // result register
  rpk_out_t result;
  rpk_out_t out_reg;
  logic     out_full;

  logic advance;

  assign cfg_ready = 1'b1;

  // move a word from input register to result register when there is room
  assign advance   = in_full && (!out_full || out_ready);
  assign in_ready  = !in_full || advance;
  assign out_valid = out_full;
  assign out_data  = out_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ms <= LongPressReset;
    end else if (cfg_valid && cfg_ready) begin
      long_press_ms <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg <= in_data;
    end
  end

  rpk_core u_core (
    .item          (in_reg),
    .st            (st),
    .long_press_ms (long_press_ms),
    .st_next       (st_next),
    .result        (result)
  );

  // state only moves when the update is committed to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st.cur_state     <= ST_OFF;
      st.held_position <= PosCenter;
      st.hold_start_ms <= '0;
      st.enable_latch  <= 1'b0;
      st.last_diag     <= DG_OK;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (advance) begin
      out_full <= 1'b1;
    end else if (out_ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg <= result;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the remote power key long-press controller
// ----------------------------------------------------------------------------
// a directed run walks through every state, the wrap of the millisecond
// clock, the spare switch code, both protect causes and a zero long-press
// time. Random runs of well-formed switch holds with some noise follow,
// under several hold times and idling profiles. Each result word is checked
// field by field against a predictor kept in the scoreboard class.
// ----------------------------------------------------------------------------

module tb;

  timeunit 1ns;
  timeprecision 1ps;

  import rpk_pkg::*;

  // spare switch code, behaves like centre
  localparam logic [1:0] PosSpare       = 2'd3;
  // power-on flags with every check passing, power-down flags ready to stop
  localparam logic [7:0] AllChecksPass  = 8'h9F;
  localparam logic [3:0] ShutdownReady  = 4'h3;
  localparam int unsigned HoldOffCycles = 60;
  localparam int unsigned PhaseUpdates  = 225;

  // --------------------------------------------------------------------------
  // scoreboard: predicts the result word of each accepted update and checks
  // result words in order
  // --------------------------------------------------------------------------
  class power_key_scoreboard;
    pwr_state_t  state_q;
    logic [1:0]  held_pos;
    logic [31:0] hold_start;
    logic        hv_latch;
    diag_t       diag_q;
    logic [15:0] hold_time;
    rpk_out_t    awaited[$];
    int unsigned errors;

    function new();
      state_q    = ST_OFF;
      held_pos   = PosCenter;
      hold_start = '0;
      hv_latch   = 1'b0;
      diag_q     = DG_OK;
      hold_time  = LongPressReset;
      errors     = 0;
    endfunction

    task report_mismatch(input string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    // works out the result word of one update and queues it
    function void note_update(input rpk_in_t u);
      rpk_out_t    res;
      logic [7:0]  fails;
      logic [31:0] held_for;
      logic [7:0]  onf;
      logic [3:0]  dnf;
      onf = u.power_on_flags;
      dnf = u.power_down_flags;
      // checks 5 and 6 fail when set, the rest when clear
      fails = {~onf[7], onf[6:5], ~onf[4:0]};
      held_for = u.now_ms - hold_start;
      res = '0;
      if (onf[6] || onf[5]) begin
        // emergency stop or class-a fault: hold and latch untouched
        state_q = ST_PROTECT;
        diag_q  = onf[6] ? DG_CLASSA : DG_STOP;
      end else if (u.power_position != PosHigh && u.power_position != PosLow) begin
        held_pos   = u.power_position;
        hold_start = u.now_ms;
        state_q    = hv_latch ? ST_ON : ST_OFF;
        diag_q     = DG_OK;
      end else if (u.power_position != held_pos) begin
        held_pos   = u.power_position;
        hold_start = u.now_ms;
      end else if (held_for < 32'(hold_time)) begin
        state_q = (u.power_position == PosHigh) ? ST_ON_REQ : ST_DOWN_REQ;
      end else if (u.power_position == PosHigh) begin
        if (hv_latch || fails == 8'd0) begin
          state_q  = ST_ON;
          hv_latch = 1'b1;
          diag_q   = DG_OK;
        end else begin
          state_q  = ST_REJECTED;
          hv_latch = 1'b0;
          diag_q   = DG_REJECT;
          res.req_refused = 1'b1;
        end
      end else if (onf[0] && onf[1] && dnf[0] && dnf[1] && !dnf[2] && !dnf[3]) begin
        state_q  = ST_OFF;
        hv_latch = 1'b0;
        diag_q   = DG_OK;
        res.hv_disable_request = 1'b1;
        res.orderly_shutdown   = 1'b1;
      end else begin
        state_q = ST_REJECTED;
        diag_q  = DG_REJECT;
        res.req_refused = 1'b1;
      end
      res.power_state       = state_q;
      res.block_mask        = fails;
      res.hv_enable_request = hv_latch;
      res.diagnostic_code   = diag_q;
      awaited.push_back(res);
    endfunction

    task check_field(input string name, input logic [7:0] got, input logic [7:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check_result(input rpk_out_t got);
      rpk_out_t want;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("result word %0h with no update pending", got));
      end else begin
        want = awaited.pop_front();
        check_field("power_state", 8'(got.power_state), 8'(want.power_state));
        check_field("block_mask", got.block_mask, want.block_mask);
        check_field("hv_enable_request", 8'(got.hv_enable_request),
                    8'(want.hv_enable_request));
        check_field("hv_disable_request", 8'(got.hv_disable_request),
                    8'(want.hv_disable_request));
        check_field("orderly_shutdown", 8'(got.orderly_shutdown),
                    8'(want.orderly_shutdown));
        check_field("req_refused", 8'(got.req_refused),
                    8'(want.req_refused));
        check_field("diagnostic_code", 8'(got.diagnostic_code), 8'(want.diagnostic_code));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // block under test
  // --------------------------------------------------------------------------
  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [LongPressW-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  rpk_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  rpk_out_t              out_data;

  power_key_scoreboard sb = new();

  // idling odds in percent, per cycle
  int unsigned in_idle_pct  = 0;
  int unsigned out_idle_pct = 0;
  // bumped by the stimulus to ask the result side for a long hold-off
  int unsigned hold_offs_asked = 0;
  // running millisecond clock of the random holds
  logic [31:0] wall_ms = '0;

  remote_power_key_fsm i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // generous ceiling, the slowest correct run needs well under a tenth of it
  initial begin
    #2_000_000;
    $display("tb: FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // driving tasks
  // --------------------------------------------------------------------------

  // offers one update word and returns at the edge that takes it; valid is
  // only lowered when a gap is wanted, so back-to-back words keep it high
  task automatic offer_update(input logic [1:0] pos, input logic [31:0] now,
                              input logic [7:0] onf, input logic [3:0] dnf);
    rpk_in_t u;
    u.power_position   = pos;
    u.now_ms           = now;
    u.power_on_flags   = onf;
    u.power_down_flags = dnf;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= u;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_update(u);
  endtask

  // stop offering and wait until every result word has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
    // two-stage pipeline, a few spare cycles catch any stray word
    repeat (4) @(posedge clk);
  endtask

  // long-press time is only changed with the block idle
  task automatic write_hold_time(input logic [15:0] ms);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= ms;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.hold_time = ms;
  endtask

  // mostly healthy flags, some with one check flipped, some anything at all
  function automatic logic [7:0] pick_on_flags();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) return AllChecksPass;
    if (pick < 80) return AllChecksPass ^ (8'd1 << $urandom_range(7));
    return 8'($urandom());
  endfunction

  function automatic logic [3:0] pick_down_flags();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 60) return ShutdownReady;
    if (pick < 85) return ShutdownReady ^ (4'd1 << $urandom_range(3));
    return 4'($urandom());
  endfunction

  // runs of one switch position with time steps around the long-press time,
  // so holds start, mature and act; one word in ten is pure noise
  task automatic run_random_phase(input int unsigned n_updates);
    int unsigned sent;
    int unsigned run_len;
    int unsigned k;
    int unsigned pick;
    int unsigned hold_ms;
    logic [1:0]  pos;
    logic [7:0]  on_f;
    logic [3:0]  dn_f;
    logic [31:0] step_ms;
    sent    = 0;
    hold_ms = sb.hold_time;
    while (sent < n_updates) begin
      pick = $urandom_range(99);
      if (pick < 40) pos = PosHigh;
      else if (pick < 80) pos = PosLow;
      else if (pick < 95) pos = PosCenter;
      else pos = PosSpare;
      run_len = $urandom_range(1, 6);
      // jump anywhere now and then, which also brings the wrap into play
      if ($urandom_range(7) == 0) wall_ms = $urandom();
      on_f = pick_on_flags();
      dn_f = pick_down_flags();
      for (k = 0; k < run_len && sent < n_updates; k++) begin
        case ($urandom_range(5))
          0: step_ms = '0;
          1: step_ms = (hold_ms == 0) ? 32'd0 : 32'(hold_ms - 1);
          2: step_ms = 32'(hold_ms);
          3: step_ms = $urandom_range(hold_ms / 2 + 1);
          4: step_ms = $urandom_range(2 * hold_ms + 2);
          default: step_ms = $urandom_range(20);
        endcase
        wall_ms = wall_ms + step_ms;
        if ($urandom_range(3) == 0) on_f = pick_on_flags();
        if ($urandom_range(3) == 0) dn_f = pick_down_flags();
        if ($urandom_range(9) == 0)
          offer_update(2'($urandom_range(3)), $urandom(), 8'($urandom()), 4'($urandom()));
        else
          offer_update(pos, wall_ms, on_f, dn_f);
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // result side: checks every word taken and drives ready, with a long
  // hold-off on request so the pipeline fills and in_ready drops
  // --------------------------------------------------------------------------
  initial begin : result_side
    int unsigned stall_left;
    int unsigned hold_offs_done;
    stall_left     = 0;
    hold_offs_done = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) sb.check_result(out_data);
      if (hold_offs_done != hold_offs_asked) begin
        hold_offs_done = hold_offs_asked;
        stall_left     = HoldOffCycles;
      end
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned phase;
    logic [15:0] phase_hold [6];
    phase_hold[0] = 16'd37;
    phase_hold[1] = 16'd65535;
    phase_hold[2] = 16'd0;
    phase_hold[3] = 16'($urandom_range(1, 400));
    phase_hold[4] = 16'd1;
    phase_hold[5] = LongPressReset;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    in_idle_pct  = 20;
    out_idle_pct = 61;

    // directed walk under the reset long-press time of 1000 ms
    offer_update(PosCenter, 32'd0, AllChecksPass, ShutdownReady);     // idle centre, off
    offer_update(PosHigh, 32'd10, AllChecksPass, ShutdownReady);      // hold starts
    offer_update(PosHigh, 32'd500, AllChecksPass, ShutdownReady);     // on requested
    offer_update(PosHigh, 32'd1010, AllChecksPass, ShutdownReady);    // exactly long: on
    offer_update(PosHigh, 32'd1011, 8'h00, 4'h0);                     // already enabled
    offer_update(PosCenter, 32'd1100, AllChecksPass, ShutdownReady);  // stays on via latch
    offer_update(PosLow, 32'd1200, AllChecksPass, ShutdownReady);     // hold starts
    offer_update(PosLow, 32'd2199, AllChecksPass, ShutdownReady);     // one short: down req
    offer_update(PosLow, 32'd2200, AllChecksPass, 4'hC);              // refused, latch kept
    offer_update(PosLow, 32'd2300, AllChecksPass, ShutdownReady);     // orderly power down
    offer_update(PosHigh, 32'd3000, AllChecksPass, ShutdownReady);
    offer_update(PosHigh, 32'd4000, 8'h1F, ShutdownReady);            // can offline: refused
    offer_update(PosHigh, 32'd4001, 8'h20, ShutdownReady);            // estop: controlled stop
    offer_update(PosLow, 32'd4002, 8'hFF, 4'hF);                      // class-a wins
    offer_update(PosSpare, 32'hFFFF_FFF0, AllChecksPass, ShutdownReady); // spare as centre
    offer_update(PosHigh, 32'hFFFF_FFF8, AllChecksPass, ShutdownReady);
    offer_update(PosHigh, 32'h0000_03E0, AllChecksPass, ShutdownReady); // long across wrap
    offer_update(PosHigh, 32'hFFFF_FFFF, 8'h60, ShutdownReady);

    // zero long-press: a hold acts on its second word
    write_hold_time(16'd0);
    offer_update(PosLow, 32'd5, AllChecksPass, ShutdownReady);
    offer_update(PosLow, 32'd5, AllChecksPass, ShutdownReady);
    offer_update(PosHigh, 32'd7, 8'h00, 4'h0);
    offer_update(PosHigh, 32'd7, 8'h00, 4'h0);
    offer_update(PosCenter, 32'hFFFF_FFFF, 8'hFF, 4'hF);

    // random phases: receiver-heavy idling, then sender-heavy, then none
    for (phase = 0; phase < 6; phase++) begin
      write_hold_time(phase_hold[phase]);
      case (phase / 2)
        0: begin
          in_idle_pct  = 20;
          out_idle_pct = 61;
        end
        1: begin
          in_idle_pct  = 61;
          out_idle_pct = 20;
        end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
        end
      endcase
      // with the sender flat out, a long receiver stall backs up the input
      if (phase == 4) hold_offs_asked++;
      run_random_phase(PhaseUpdates);
    end

    drain();
    if (sb.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
